@@ hw/rtl/rsti_pkg.sv @@
// Shared types, character codes and status codes for the radix string-to-integer block.
`default_nettype none

package rsti_pkg;

    // Character codes used by the digit decoder.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] LETTER_OFS = 8'h37;  // 'A' minus ten

    // Radix limits and reset value.
    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd10;

    // Arithmetic unit width: holds a 31-bit magnitude times a 6-bit base plus a digit.
    localparam int unsigned ALU_W = 38;
    localparam logic [ALU_W-1:0] MAX_POSITIVE = ALU_W'(32'h7FFF_FFFF);

    // Status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_DIGITS  = 2'd1;
    localparam logic [1:0] ST_BAD_SYMBOL = 2'd2;
    localparam logic [1:0] ST_OVERFLOW   = 2'd3;

    // Arithmetic unit operations.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // One request to the shared arithmetic unit.
    typedef struct packed {
        logic [1:0]       op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

endpackage

`default_nettype wire

@@ hw/rtl/rsti_alu.sv @@
// Shared arithmetic unit: add, subtract, or multiply a magnitude by the base.
`default_nettype none

module rsti_alu (
    input  wire rsti_pkg::t_alu_req    i_req,
    output logic [rsti_pkg::ALU_W-1:0] o_res
);
    import rsti_pkg::*;

    // Only the low 31 bits of a and 6 bits of b take part in a multiply.
    logic [36:0] mul_res;

    assign mul_res = {6'd0, i_req.a[30:0]} * {31'd0, i_req.b[5:0]};

    // Operation select.
    always_comb begin
        case (i_req.op)
            OP_ADD:  o_res = i_req.a + i_req.b;
            OP_SUB:  o_res = i_req.a - i_req.b;
            OP_MUL:  o_res = ALU_W'(mul_res);
            default: o_res = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/radix_string_to_integer.sv @@
// Top level: character stream to signed 32-bit integer in a configurable radix.
//
//  Channel   | Direction | Ports                      | Word
//  ----------+-----------+----------------------------+-------------------------------
//  s_axis    | in        | tvalid, tready, tdata[7:0] | char_code
//  m_axis    | out       | tvalid, tready, tdata[39:0]| value[31:0], status[33:32]
//  cfg       | in        | wr_en, wr_data[5:0]        | radix
//
// A digit steps through accept, decode, multiply by the base, then add the
// digit with the overflow compare; all arithmetic goes through one shared unit.
// A minus, a rejected symbol or a character after an error ends after decode.
// The terminator goes through accept, decode and a final step, and holds in
// its final step while an earlier result waits for i_m_axis_tready.
// Reset is synchronous and active low; it sets radix to 10 and clears the parse.
`default_nettype none

module radix_string_to_integer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration.
    input  wire         i_cfg_wr_en,
    input  wire  [5:0]  i_cfg_wr_data,
    // Input stream.
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] char_code
    // Output stream.
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [31:0] value, [33:32] status, [39:34] zero
);
    import rsti_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [5:0]       r_radix;
    logic [7:0]       r_char;
    logic [5:0]       r_digit, n_digit;
    logic [ALU_W-1:0] r_prod, n_prod;
    logic [30:0]      r_acc, n_acc;
    logic             r_neg, n_neg;
    logic             r_at_start, n_at_start;
    logic             r_seen, n_seen;
    logic [1:0]       r_err, n_err;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_value, n_out_value;
    logic [1:0]       r_out_status, n_out_status;

    t_alu_req         alu_req;
    logic [ALU_W-1:0] alu_res;
    logic [5:0]       eff_base;
    logic [7:0]       raw_digit;
    logic             is_dec, is_alpha;
    logic             out_free;
    logic [1:0]       fin_status;

    rsti_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // Radix clamped into the supported range.
    always_comb begin
        if (r_radix < RADIX_MIN) begin
            eff_base = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            eff_base = RADIX_MAX;
        end else begin
            eff_base = r_radix;
        end
    end

    // Character classification; lowercase letters land far above any base.
    assign is_dec   = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign is_alpha = ((r_char >= CH_UPPER_A) && (r_char <= CH_UPPER_Z))
                   || ((r_char >= CH_LOWER_A) && (r_char <= CH_LOWER_Z));
    assign raw_digit = is_dec ? (r_char - CH_ZERO) : (r_char - LETTER_OFS);

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign fin_status = ((r_err == ST_OK) && !r_seen) ? ST_NO_DIGITS : r_err;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_status, r_out_value};

    // Sequencer and arithmetic unit operand selection.
    always_comb begin
        n_state      = r_state;
        n_digit      = r_digit;
        n_prod       = r_prod;
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_at_start   = r_at_start;
        n_seen       = r_seen;
        n_err        = r_err;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        alu_req.op   = OP_ADD;
        alu_req.a    = ALU_W'(r_acc);
        alu_req.b    = '0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                if (r_char == CH_NUL) begin
                    n_state = S_FIN;
                end else if (r_err != ST_OK) begin
                    n_state = S_IDLE;
                end else if (r_at_start && (r_char == CH_MINUS)) begin
                    n_neg      = 1'b1;
                    n_at_start = 1'b0;
                end else begin
                    n_at_start = 1'b0;
                    if (!(is_dec || is_alpha) || (raw_digit >= {2'b00, eff_base})) begin
                        n_err = ST_BAD_SYMBOL;
                    end else begin
                        n_digit = raw_digit[5:0];
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                // Magnitude times base.
                alu_req.op = OP_MUL;
                alu_req.a  = ALU_W'(r_acc);
                alu_req.b  = ALU_W'(eff_base);
                n_prod     = alu_res;
                n_state    = S_ADD;
            end
            S_ADD: begin
                // Add the digit and test against the largest positive value.
                alu_req.op = OP_ADD;
                alu_req.a  = r_prod;
                alu_req.b  = ALU_W'(r_digit);
                if (alu_res > MAX_POSITIVE) begin
                    n_err = ST_OVERFLOW;
                end else begin
                    n_acc  = alu_res[30:0];
                    n_seen = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_FIN: begin
                // Apply the sign with the shared unit and load the output word.
                alu_req.op = r_neg ? OP_SUB : OP_ADD;
                alu_req.a  = r_neg ? '0 : ALU_W'(r_acc);
                alu_req.b  = r_neg ? ALU_W'(r_acc) : '0;
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = fin_status;
                    n_out_value  = (fin_status == ST_OK) ? alu_res[31:0] : 32'd0;
                    n_acc        = '0;
                    n_neg        = 1'b0;
                    n_at_start   = 1'b1;
                    n_seen       = 1'b0;
                    n_err        = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_RESET;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_at_start  <= 1'b1;
            r_seen      <= 1'b0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_at_start  <= n_at_start;
            r_seen      <= n_seen;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_radix <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_char <= i_s_axis_tdata;
        end
        r_digit      <= n_digit;
        r_prod       <= n_prod;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

endmodule

`default_nettype wire
